// ----- rtl/cit_pkg.sv -----
// Shared types and constants of the command item tokenizer.
package cit_pkg;

   localparam int CHAR_W   = 8;
   localparam int CFG_W    = 13;
   localparam int CODE_W   = 3;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [CFG_W-1:0] MAX_CHARS_RESET = 13'd256;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3d;
   localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
   localparam logic [CHAR_W-1:0] CH_UP_N   = 8'h4e;
   localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;
   localparam logic [CHAR_W-1:0] CH_LO_N   = 8'h6e;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_QUOTED = 2'd1,
      PH_STAR   = 2'd2,
      PH_PLAIN  = 2'd3
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_NOTHING  = 3'd0,
      CODE_EQUAL    = 3'd1,
      CODE_QUOTED   = 3'd2,
      CODE_UNQUOTED = 3'd3,
      CODE_ERROR    = 3'd4
   } code_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              is_last;
      code_type          item_code;
      logic              push_back;
   } rsp_type;

endpackage

// ----- rtl/cit_front.sv -----
// Front end: takes one request per cycle, tracks the item phase and classifies the result.
module cit_front
   import cit_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CFG_W-1:0]  max_chars,
   input  logic              in_valid,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              end_of_stream,
   output logic              res_valid,
   output rsp_type           res
);

   phase_type         phase_ff, phase_in;
   logic [CFG_W-1:0]  remaining_ff, remaining_in;

   logic [CFG_W-1:0]  buf_size;
   logic [CFG_W-1:0]  rem_dec;
   logic              line_end;
   logic              is_blank;
   logic              do_end;
   logic              end_pb;
   code_type          end_code;
   logic              do_char;
   logic [CHAR_W-1:0] ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         remaining_ff <= '0;
      end else if (in_valid) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   always_comb begin
      if (32'(max_chars) > 32'(MAX_LEN)) begin
         buf_size = CFG_W'(MAX_LEN);
      end else begin
         buf_size = max_chars;
      end
      line_end     = !end_of_stream && (char_code == CH_NUL || char_code == CH_LF);
      is_blank     = !end_of_stream && (char_code == CH_SPACE || char_code == CH_TAB);
      rem_dec      = remaining_ff - 1'b1;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      do_end       = 1'b0;
      end_pb       = 1'b0;
      end_code     = CODE_NOTHING;
      do_char      = 1'b0;
      ch           = char_code;

      case (phase_ff)
         PH_SKIP: begin
            if (buf_size == '0) begin
               do_end = 1'b1;
               end_pb = !end_of_stream;
            end else if (is_blank) begin
               do_end = 1'b0;
            end else if (end_of_stream) begin
               do_end = 1'b1;
            end else if (line_end || char_code == CH_SEMI) begin
               do_end = 1'b1;
               end_pb = 1'b1;
            end else if (char_code == CH_EQUAL) begin
               do_end   = 1'b1;
               end_code = CODE_EQUAL;
            end else if (char_code == CH_QUOTE) begin
               phase_in     = PH_QUOTED;
               remaining_in = buf_size;
            end else if (buf_size == CFG_W'(1)) begin
               do_end   = 1'b1;
               end_code = CODE_ERROR;
            end else begin
               phase_in     = PH_PLAIN;
               remaining_in = buf_size - 1'b1;
               do_char      = 1'b1;
            end
         end
         PH_QUOTED: begin
            if (remaining_ff == '0) begin
               do_end = 1'b1;
            end else begin
               remaining_in = rem_dec;
               if (end_of_stream) begin
                  do_end   = 1'b1;
                  end_code = CODE_ERROR;
               end else if (line_end) begin
                  do_end   = 1'b1;
                  end_code = CODE_ERROR;
                  end_pb   = 1'b1;
               end else if (char_code == CH_QUOTE) begin
                  do_end   = 1'b1;
                  end_code = CODE_QUOTED;
               end else if (char_code == CH_STAR) begin
                  phase_in = PH_STAR;
               end else if (rem_dec == '0) begin
                  do_end = 1'b1;
               end else begin
                  do_char = 1'b1;
               end
            end
         end
         PH_STAR: begin
            if (end_of_stream) begin
               do_end   = 1'b1;
               end_code = CODE_ERROR;
            end else if (line_end) begin
               do_end   = 1'b1;
               end_code = CODE_ERROR;
               end_pb   = 1'b1;
            end else begin
               if (char_code == CH_LO_N || char_code == CH_UP_N) begin
                  ch = CH_LF;
               end else if (char_code == CH_LO_E || char_code == CH_UP_E) begin
                  ch = CH_ESC;
               end
               phase_in = PH_QUOTED;
               if (remaining_ff == '0) begin
                  do_end = 1'b1;
               end else begin
                  do_char = 1'b1;
               end
            end
         end
         PH_PLAIN: begin
            if (remaining_ff == '0) begin
               do_end   = 1'b1;
               end_code = CODE_ERROR;
            end else begin
               remaining_in = rem_dec;
               if (end_of_stream || is_blank || char_code == CH_EQUAL) begin
                  do_end   = 1'b1;
                  end_code = CODE_UNQUOTED;
               end else if (line_end || char_code == CH_SEMI) begin
                  do_end   = 1'b1;
                  end_code = CODE_UNQUOTED;
                  end_pb   = 1'b1;
               end else if (rem_dec == '0) begin
                  do_end   = 1'b1;
                  end_code = CODE_ERROR;
               end else begin
                  do_char = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      if (do_end) begin
         phase_in     = PH_SKIP;
         remaining_in = '0;
      end

      res_valid = do_end || do_char;
      if (do_end) begin
         res.out_char  = '0;
         res.is_last   = 1'b1;
         res.item_code = end_code;
         res.push_back = end_pb;
      end else begin
         res.out_char  = do_char ? ch : '0;
         res.is_last   = 1'b0;
         res.item_code = CODE_NOTHING;
         res.push_back = 1'b0;
      end
   end

   a_end_returns_to_skip: assert property (@(posedge clock) disable iff (reset)
      (in_valid && res_valid && res.is_last) |=> (phase_ff == PH_SKIP && remaining_ff == '0))
      else $error("item end did not return to blank skipping");

   a_star_resumes_quoted: assert property (@(posedge clock) disable iff (reset)
      (in_valid && phase_ff == PH_STAR) |=> (phase_ff == PH_QUOTED || phase_ff == PH_SKIP))
      else $error("escape left the quoted item in a wrong phase");

   a_plain_counts_down: assert property (@(posedge clock) disable iff (reset)
      (in_valid && phase_ff == PH_PLAIN && !(res_valid && res.is_last))
      |=> remaining_ff == $past(remaining_ff) - 1'b1)
      else $error("unquoted item budget did not advance");

endmodule

// ----- rtl/cit_queue.sv -----
// Back end: short result queue between the classifier and the result port.
module cit_queue
   import cit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  rsp_type push_data,
   input  logic    pop_en,
   output rsp_type head,
   output logic    is_full,
   output logic    is_empty
);

   rsp_type              entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      is_full   = (count_ff == Q_CNT_W'(Q_DEPTH));
      is_empty  = (count_ff == '0);
      do_push   = push_en && !is_full;
      do_pop    = pop_en && !is_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
      head      = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overfilled");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("result queue lost a write");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue lost a read");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      Q_PTR_W'(wr_ptr_ff - rd_ptr_ff) == Q_PTR_W'(count_ff))
      else $error("result queue pointers disagree with fill level");

endmodule

// ----- rtl/command_item_tokenizer_core.sv -----
// Top level of the command item tokenizer: register, front end and result queue.
//
// One request (a character or an end-of-stream mark) is taken every cycle while
// full is low; each request gives zero or one result, written the same cycle
// into a four-entry result queue and visible on the rsp_ ports from the next
// cycle if the queue was empty. full rises when it holds four results; with pop
// held high the block sustains one request per cycle. max_chars resets to 256
// and is clamped to MAX_LEN; change it only while no item is in progress.
module command_item_tokenizer_core
   import cit_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   input  logic              push,
   output logic              full,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_end_of_stream,
   output logic              empty,
   input  logic              pop,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_is_last,
   output logic [CODE_W-1:0] rsp_item_code,
   output logic              rsp_push_back
);

   logic [CFG_W-1:0] max_chars_ff, max_chars_in;
   logic             req_accept;
   logic             res_valid;
   rsp_type          res;
   rsp_type          head;

   always_comb begin
      max_chars_in = csr_wr_en ? csr_wr_data : max_chars_ff;
      req_accept   = push && !full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   cit_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .max_chars     (max_chars_ff),
      .in_valid      (req_accept),
      .char_code     (req_char_code),
      .end_of_stream (req_end_of_stream),
      .res_valid     (res_valid),
      .res           (res)
   );

   cit_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_accept && res_valid),
      .push_data (res),
      .pop_en    (pop),
      .head      (head),
      .is_full   (full),
      .is_empty  (empty)
   );

   assign rsp_out_char  = head.out_char;
   assign rsp_is_last   = head.is_last;
   assign rsp_item_code = head.item_code;
   assign rsp_push_back = head.push_back;

endmodule
